FILE: rtl/dws_pkg.sv
package dws_pkg;

    localparam int unsigned DUTY_W     = 8;
    localparam int unsigned BRAKE_W    = 4;
    localparam int unsigned TGT_W      = 15;
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [DUTY_W-1:0] LEVEL_RESET = 8'd95;
    localparam logic [DUTY_W-1:0] TURN_DROP   = 8'd20;

    typedef enum logic [2:0] {
        MODE_IDLE         = 3'd0,
        MODE_STRAIGHT     = 3'd1,
        MODE_STRAIGHT_BRK = 3'd2,
        MODE_TURN         = 3'd3,
        MODE_TURN_BRK     = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        FUNC_TICK     = 2'd0,
        FUNC_STRAIGHT = 2'd1,
        FUNC_TURN     = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        REG_TARGET_MM     = 3'd0,
        REG_TURN_MULTIPLE = 3'd1,
        REG_ROTATION      = 3'd2,
        REG_BASE_DUTY     = 3'd3,
        REG_DUTY_MAX      = 3'd4,
        REG_DUTY_MIN      = 3'd5,
        REG_SLOW_COUNT    = 3'd6,
        REG_START_BOOST   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [13:0]       target_mm;
        logic [2:0]        turn_multiple;
        logic [11:0]       rotation_pulses;
        logic [DUTY_W-1:0] base_duty;
        logic [DUTY_W-1:0] duty_max;
        logic [DUTY_W-1:0] duty_min;
        logic [15:0]       straight_slow_count;
        logic [DUTY_W-1:0] start_boost;
    } t_cfg;

    typedef struct packed {
        logic       ms_tick;
        logic       right_pulse;
        logic       left_pulse;
        logic [1:0] func;
    } t_item;

    typedef struct packed {
        logic              done_res;
        logic              busy_res;
        logic [DUTY_W-1:0] right_duty;
        logic [DUTY_W-1:0] left_duty;
        logic              right_rev;
        logic              right_fwd;
        logic              left_rev;
        logic              left_fwd;
    } t_result;

    // Exact floor(x/3) for any 8-bit x: multiply by 171, drop 9 bits.
    function automatic logic [DUTY_W-1:0] div3(input logic [DUTY_W-1:0] x);
        logic [15:0] prod;
        prod = 16'(x) * 16'd171;
        return DUTY_W'(prod[15:9]);
    endfunction

endpackage

FILE: rtl/dws_cfg.sv
module dws_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dws_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [dws_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [dws_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output dws_pkg::t_cfg                       o_cfg
);
    import dws_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_mm           <= 14'd610;
            r_cfg.turn_multiple       <= 3'd1;
            r_cfg.rotation_pulses     <= 12'd880;
            r_cfg.base_duty           <= 8'd95;
            r_cfg.duty_max            <= 8'd160;
            r_cfg.duty_min            <= 8'd0;
            r_cfg.straight_slow_count <= 16'd1100;
            r_cfg.start_boost         <= 8'd0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_TARGET_MM:     r_cfg.target_mm           <= pwdata[13:0];
                REG_TURN_MULTIPLE: r_cfg.turn_multiple       <= pwdata[2:0];
                REG_ROTATION:      r_cfg.rotation_pulses     <= pwdata[11:0];
                REG_BASE_DUTY:     r_cfg.base_duty           <= pwdata[7:0];
                REG_DUTY_MAX:      r_cfg.duty_max            <= pwdata[7:0];
                REG_DUTY_MIN:      r_cfg.duty_min            <= pwdata[7:0];
                REG_SLOW_COUNT:    r_cfg.straight_slow_count <= pwdata[15:0];
                REG_START_BOOST:   r_cfg.start_boost         <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_TARGET_MM:     prdata = APB_DATA_W'(r_cfg.target_mm);
            REG_TURN_MULTIPLE: prdata = APB_DATA_W'(r_cfg.turn_multiple);
            REG_ROTATION:      prdata = APB_DATA_W'(r_cfg.rotation_pulses);
            REG_BASE_DUTY:     prdata = APB_DATA_W'(r_cfg.base_duty);
            REG_DUTY_MAX:      prdata = APB_DATA_W'(r_cfg.duty_max);
            REG_DUTY_MIN:      prdata = APB_DATA_W'(r_cfg.duty_min);
            REG_SLOW_COUNT:    prdata = APB_DATA_W'(r_cfg.straight_slow_count);
            REG_START_BOOST:   prdata = APB_DATA_W'(r_cfg.start_boost);
        endcase
    end

endmodule

FILE: rtl/dws_core.sv
module dws_core #(
    parameter int unsigned STRAIGHT_BRAKE_MS = 7,
    parameter int unsigned TURN_BRAKE_MS     = 3,
    parameter int unsigned COUNT_WIDTH       = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  dws_pkg::t_item    i_item,
    input  dws_pkg::t_cfg     i_cfg,
    output dws_pkg::t_result  o_res
);
    import dws_pkg::*;

    localparam int unsigned CW  = COUNT_WIDTH;
    localparam int unsigned EW  = (CW > TGT_W) ? CW : TGT_W;
    localparam int unsigned MW  = CW + 4;
    localparam int unsigned SW  = (CW > 16) ? CW : 16;
    localparam int unsigned CW1 = CW + 1;
    localparam logic [CW-1:0]      CNT_MAX = {CW{1'b1}};
    localparam logic [BRAKE_W-1:0] STR_MS  = BRAKE_W'(STRAIGHT_BRAKE_MS);
    localparam logic [BRAKE_W-1:0] TRN_MS  = BRAKE_W'(TURN_BRAKE_MS);

    t_mode              r_mode,  n_mode;
    logic [CW-1:0]      r_lcnt,  n_lcnt;
    logic [CW-1:0]      r_rcnt,  n_rcnt;
    logic [CW-1:0]      r_tgt,   n_tgt;
    logic [DUTY_W-1:0]  r_rlvl,  n_rlvl;
    logic [DUTY_W-1:0]  r_llvl,  n_llvl;
    logic [1:0]         r_phase, n_phase;
    logic [BRAKE_W-1:0] r_btmr,  n_btmr;
    logic               r_rot,   n_rot;

    logic [CW-1:0]      lc_inc, rc_inc;
    logic [MW-1:0]      l10, r10, t7, t8;
    logic [CW1-1:0]     l_near, r_near;
    logic [DUTY_W:0]    boost_sum;
    logic [BRAKE_W-1:0] tmr_dec;
    logic [1:0]         ph;
    logic               done;

    function automatic logic [CW-1:0] sat_tgt(input logic [TGT_W-1:0] v);
        logic [EW-1:0] ve;
        ve = EW'(v);
        if (ve > EW'(CNT_MAX)) return CNT_MAX;
        return CW'(ve);
    endfunction

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c, input logic p);
        return (p && c != CNT_MAX) ? c + CW'(1) : c;
    endfunction

    // Step the right duty toward the left wheel; raise clamps high, lower clamps low.
    function automatic logic [DUTY_W-1:0] trim(
        input logic [DUTY_W-1:0] lvl,
        input logic [2:0]        up,
        input logic [2:0]        down,
        input logic [CW-1:0]     lc,
        input logic [CW-1:0]     rc,
        input logic [DUTY_W-1:0] dmax,
        input logic [DUTY_W-1:0] dmin
    );
        logic [DUTY_W:0] up_sum;
        logic [DUTY_W:0] low_lim;
        up_sum  = {1'b0, lvl} + (DUTY_W+1)'(up);
        low_lim = {1'b0, dmin} + (DUTY_W+1)'(down);
        if (lc > rc) return (up_sum > {1'b0, dmax}) ? dmax : up_sum[DUTY_W-1:0];
        if (lc < rc) return ({1'b0, lvl} < low_lim) ? dmin : lvl - DUTY_W'(down);
        return lvl;
    endfunction

    assign lc_inc    = sat_inc(r_lcnt, i_item.left_pulse);
    assign rc_inc    = sat_inc(r_rcnt, i_item.right_pulse);
    // 10*n against 7*t and 8*t with shifts, adds and a subtract
    assign l10       = (MW'(lc_inc) << 3) + (MW'(lc_inc) << 1);
    assign r10       = (MW'(rc_inc) << 3) + (MW'(rc_inc) << 1);
    assign t7        = (MW'(r_tgt) << 3) - MW'(r_tgt);
    assign t8        = MW'(r_tgt) << 3;
    assign l_near    = CW1'(lc_inc) + CW1'(2);
    assign r_near    = CW1'(rc_inc) + CW1'(2);
    assign boost_sum = {1'b0, i_cfg.base_duty} + {1'b0, i_cfg.start_boost};
    assign tmr_dec   = (r_btmr != '0) ? r_btmr - BRAKE_W'(1) : r_btmr;

    always_comb begin
        n_mode  = r_mode;
        n_lcnt  = r_lcnt;
        n_rcnt  = r_rcnt;
        n_tgt   = r_tgt;
        n_rlvl  = r_rlvl;
        n_llvl  = r_llvl;
        n_phase = r_phase;
        n_btmr  = r_btmr;
        n_rot   = r_rot;
        ph      = r_phase;
        done    = 1'b0;

        case (i_item.func)
            FUNC_STRAIGHT: begin
                n_lcnt  = '0;
                n_rcnt  = '0;
                n_tgt   = sat_tgt({i_cfg.target_mm, 1'b0});
                n_llvl  = boost_sum[DUTY_W] ? {DUTY_W{1'b1}} : boost_sum[DUTY_W-1:0];
                n_phase = 2'd0;
                n_btmr  = '0;
                n_rot   = 1'b0;
                n_mode  = MODE_STRAIGHT;
            end
            FUNC_TURN: begin
                n_lcnt  = '0;
                n_rcnt  = '0;
                n_tgt   = sat_tgt(TGT_W'(i_cfg.rotation_pulses) * TGT_W'(i_cfg.turn_multiple));
                n_llvl  = (i_cfg.base_duty >= TURN_DROP) ? i_cfg.base_duty - TURN_DROP : '0;
                n_phase = 2'd0;
                n_btmr  = '0;
                n_rot   = 1'b1;
                n_mode  = MODE_TURN;
            end
            default: begin
                n_lcnt = lc_inc;
                n_rcnt = rc_inc;
                unique case (r_mode)
                    MODE_STRAIGHT: begin
                        if (rc_inc > r_tgt || lc_inc > r_tgt) begin
                            n_mode = MODE_STRAIGHT_BRK;
                            n_btmr = STR_MS;
                        end else begin
                            if (SW'(lc_inc) >= SW'(i_cfg.straight_slow_count)) begin
                                n_llvl = i_cfg.base_duty >> 1;
                                ph     = 2'd1;
                            end
                            n_phase = ph;
                            n_rlvl  = trim(r_rlvl, (ph != 2'd0) ? 3'd5 : 3'd6,
                                           (ph != 2'd0) ? 3'd2 : 3'd3, lc_inc, rc_inc,
                                           i_cfg.duty_max, i_cfg.duty_min);
                        end
                    end
                    MODE_STRAIGHT_BRK: begin
                        if (i_item.ms_tick) begin
                            n_btmr = tmr_dec;
                            if (tmr_dec == '0) begin
                                n_mode = MODE_IDLE;
                                n_lcnt = '0;
                                n_rcnt = '0;
                                done   = 1'b1;
                            end
                        end
                    end
                    MODE_TURN: begin
                        if (rc_inc > r_tgt) begin
                            n_mode = MODE_IDLE;
                            n_rot  = 1'b0;
                            n_lcnt = '0;
                            n_rcnt = '0;
                            done   = 1'b1;
                        end else begin
                            if (l10 >= t7 && r10 >= t7) begin
                                n_llvl = i_cfg.base_duty >> 1;
                                ph     = 2'd1;
                                if (l10 >= t8 && r10 >= t8) begin
                                    n_llvl = div3(i_cfg.base_duty);
                                    ph     = 2'd2;
                                    if (l_near >= CW1'(r_tgt) && r_near >= CW1'(r_tgt)) begin
                                        n_mode = MODE_TURN_BRK;
                                        n_btmr = TRN_MS;
                                        n_rot  = 1'b0;
                                    end
                                end
                            end
                            n_phase = ph;
                            case (ph)
                                2'd2:    n_rlvl = trim(r_rlvl, 3'd2, 3'd1, lc_inc, rc_inc,
                                                       i_cfg.duty_max, i_cfg.duty_min);
                                2'd1:    n_rlvl = trim(r_rlvl, 3'd4, 3'd3, lc_inc, rc_inc,
                                                       i_cfg.duty_max, i_cfg.duty_min);
                                default: n_rlvl = trim(r_rlvl, 3'd5, 3'd4, lc_inc, rc_inc,
                                                       i_cfg.duty_max, i_cfg.duty_min);
                            endcase
                        end
                    end
                    MODE_TURN_BRK: begin
                        if (i_item.ms_tick) begin
                            n_btmr = tmr_dec;
                            if (tmr_dec == '0) n_mode = MODE_TURN;
                        end
                    end
                    default: n_mode = MODE_IDLE;
                endcase
            end
        endcase

        o_res            = '0;
        o_res.left_duty  = n_llvl;
        o_res.right_duty = n_rlvl;
        o_res.busy_res   = (n_mode != MODE_IDLE);
        o_res.done_res   = done;
        unique case (n_mode)
            MODE_STRAIGHT: begin
                o_res.left_fwd  = 1'b1;
                o_res.right_fwd = 1'b1;
            end
            MODE_STRAIGHT_BRK: begin
                o_res.left_rev  = 1'b1;
                o_res.right_rev = 1'b1;
            end
            MODE_TURN: begin
                o_res.left_fwd  = n_rot;
                o_res.right_rev = n_rot;
            end
            MODE_TURN_BRK: begin
                o_res.left_rev  = 1'b1;
                o_res.right_fwd = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_lcnt  <= '0;
            r_rcnt  <= '0;
            r_tgt   <= '0;
            r_rlvl  <= LEVEL_RESET;
            r_llvl  <= LEVEL_RESET;
            r_phase <= 2'd0;
            r_btmr  <= '0;
            r_rot   <= 1'b0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_lcnt  <= n_lcnt;
            r_rcnt  <= n_rcnt;
            r_tgt   <= n_tgt;
            r_rlvl  <= n_rlvl;
            r_llvl  <= n_llvl;
            r_phase <= n_phase;
            r_btmr  <= n_btmr;
            r_rot   <= n_rot;
        end
    end

endmodule

FILE: rtl/two_wheel_encoder_drive_sync_unit.sv
// Channel   Dir  Handshake                          Payload
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready  one tick: func, pulses, ms flag
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready  one result: gates, duties, status
// apb       in   psel, penable, pwrite, pready      eight config registers at 4*i
//
// One beat in gives one beat out, in the cycle after the accept; a new beat is
// taken every cycle unless the output stalls. The drive state and the output
// register update on the accepting edge. The output register decouples the sides:
// input is taken whenever the output register is empty or drained in the same cycle.
// Synchronous active-low reset clears the drive state (both levels to 95,
// idle) and the config registers to their defaults; no clearing pass.
module two_wheel_encoder_drive_sync_unit #(
    parameter int unsigned STRAIGHT_BRAKE_MS = 7,
    parameter int unsigned TURN_BRAKE_MS     = 3,
    parameter int unsigned COUNT_WIDTH       = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [1:0] func, [2] left_pulse, [3] right_pulse, [4] ms_tick, [7:5] zero
    input  logic [7:0]                      i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [0] left_fwd, [1] left_rev, [2] right_fwd, [3] right_rev,
    // [11:4] left_duty, [19:12] right_duty, [20] busy_res, [21] done_res, [23:22] zero
    output logic [23:0]                     o_m_axis_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dws_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [dws_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [dws_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import dws_pkg::*;

    t_cfg    w_cfg;
    t_item   w_item;
    t_result w_res;
    t_result r_out;
    logic    r_out_valid;
    logic    w_step;

    // take a beat when the output slot is free or being drained
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_step          = i_s_axis_tvalid && o_s_axis_tready;
    assign w_item          = t_item'(i_s_axis_tdata[4:0]);

    dws_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dws_core #(
        .STRAIGHT_BRAKE_MS (STRAIGHT_BRAKE_MS),
        .TURN_BRAKE_MS     (TURN_BRAKE_MS),
        .COUNT_WIDTH       (COUNT_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_item  (w_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // output register: load on accept, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out};

    // a wheel is never driven both ways at once
    a_no_shoot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(r_out.left_fwd && r_out.left_rev)
                         && !(r_out.right_fwd && r_out.right_rev))
        else $error("wheel gate driven forward and reverse together");

    // a finished move reports idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_out.done_res) |-> !r_out.busy_res)
        else $error("done reported while still busy");

    // an accepted start shows a busy result on the next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && (w_item.func == FUNC_STRAIGHT || w_item.func == FUNC_TURN))
        |=> (o_m_axis_tvalid && r_out.busy_res && !r_out.done_res))
        else $error("start beat did not produce a busy result");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

FILE: dv/drive_sync_checker.sv
module drive_sync_checker #(
    parameter int unsigned STRAIGHT_BRAKE_MS = 7,
    parameter int unsigned TURN_BRAKE_MS     = 3,
    parameter int unsigned COUNT_WIDTH       = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // [1:0] func, [2] left_pulse, [3] right_pulse, [4] ms_tick, [7:5] zero
    input  logic [7:0]                     i_s_tdata,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // [0] left_fwd, [1] left_rev, [2] right_fwd, [3] right_rev,
    // [11:4] left_duty, [19:12] right_duty, [20] busy_res, [21] done_res, [23:22] zero
    input  logic [23:0]                    i_m_tdata,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [dws_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [dws_pkg::APB_DATA_W-1:0] i_pwdata,
    input  logic [dws_pkg::APB_DATA_W-1:0] i_prdata,
    input  logic                           i_pready,
    output int                             o_fail_count,
    output int                             o_pending
);
    import dws_pkg::*;

    localparam int COUNT_MAX = (1 << COUNT_WIDTH) - 1;

    // register copies
    int target_mm_r, turn_mult_r, rotation_r, base_duty_r;
    int duty_max_r, duty_min_r, slow_count_r, boost_r;

    // drive state
    t_mode       mode;
    int          left_cnt, right_cnt, target_cnt, slow_phase;
    logic [7:0]  left_lvl, right_lvl;
    logic [3:0]  brake_left;
    bit          turning_on;

    t_result     drive_results_due[$];
    int          fails   = 0;
    int          pending = 0;
    int          beats_out = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        fails++;
    endtask

    function automatic void restore_defaults();
        target_mm_r  = 610;  turn_mult_r = 1;   rotation_r = 880;
        base_duty_r  = 95;   duty_max_r  = 160; duty_min_r = 0;
        slow_count_r = 1100; boost_r     = 0;
        mode       = MODE_IDLE;
        left_cnt   = 0;
        right_cnt  = 0;
        target_cnt = 0;
        slow_phase = 0;
        left_lvl   = LEVEL_RESET;
        right_lvl  = LEVEL_RESET;
        brake_left = '0;
        turning_on = 1'b0;
        drive_results_due.delete();
    endfunction

    function automatic int clip_count(input int v);
        return (v > COUNT_MAX) ? COUNT_MAX : v;
    endfunction

    function automatic logic [31:0] reg_value(input t_reg_idx idx);
        case (idx)
            REG_TARGET_MM:     return 32'(target_mm_r);
            REG_TURN_MULTIPLE: return 32'(turn_mult_r);
            REG_ROTATION:      return 32'(rotation_r);
            REG_BASE_DUTY:     return 32'(base_duty_r);
            REG_DUTY_MAX:      return 32'(duty_max_r);
            REG_DUTY_MIN:      return 32'(duty_min_r);
            REG_SLOW_COUNT:    return 32'(slow_count_r);
            default:           return 32'(boost_r);
        endcase
    endfunction

    function automatic void write_reg(input t_reg_idx idx, input logic [31:0] v);
        case (idx)
            REG_TARGET_MM:     target_mm_r  = int'(v[13:0]);
            REG_TURN_MULTIPLE: turn_mult_r  = int'(v[2:0]);
            REG_ROTATION:      rotation_r   = int'(v[11:0]);
            REG_BASE_DUTY:     base_duty_r  = int'(v[7:0]);
            REG_DUTY_MAX:      duty_max_r   = int'(v[7:0]);
            REG_DUTY_MIN:      duty_min_r   = int'(v[7:0]);
            REG_SLOW_COUNT:    slow_count_r = int'(v[15:0]);
            default:           boost_r      = int'(v[7:0]);
        endcase
    endfunction

    // Raise clamps only to the max, lowering only to the min.
    function automatic void trim_right(input int up, input int down);
        int lv;
        lv = right_lvl;
        if (left_cnt > right_cnt) begin
            lv = lv + up;
            if (lv > duty_max_r) lv = duty_max_r;
        end else if (left_cnt < right_cnt) begin
            lv = lv - down;
            if (lv < duty_min_r) lv = duty_min_r;
        end
        right_lvl = lv[7:0];
    endfunction

    function automatic t_result step_drive(input t_item it);
        t_result r;
        bit      done;
        int      b;
        int      sum;
        r    = '0;
        done = 1'b0;
        case (t_func'(it.func))
            FUNC_STRAIGHT: begin
                left_cnt   = 0;
                right_cnt  = 0;
                target_cnt = clip_count(2 * target_mm_r);
                sum        = base_duty_r + boost_r;
                left_lvl   = (sum > 255) ? 8'd255 : sum[7:0];
                slow_phase = 0;
                brake_left = '0;
                turning_on = 1'b0;
                mode       = MODE_STRAIGHT;
            end
            FUNC_TURN: begin
                left_cnt   = 0;
                right_cnt  = 0;
                target_cnt = clip_count(rotation_r * turn_mult_r);
                sum        = base_duty_r - int'(TURN_DROP);
                left_lvl   = (sum < 0) ? 8'd0 : sum[7:0];
                slow_phase = 0;
                brake_left = '0;
                turning_on = 1'b1;
                mode       = MODE_TURN;
            end
            default: begin
                left_cnt  = clip_count(left_cnt + int'(it.left_pulse));
                right_cnt = clip_count(right_cnt + int'(it.right_pulse));
                case (mode)
                    MODE_STRAIGHT: begin
                        if (right_cnt > target_cnt || left_cnt > target_cnt) begin
                            mode       = MODE_STRAIGHT_BRK;
                            brake_left = 4'(STRAIGHT_BRAKE_MS);
                        end else begin
                            if (left_cnt >= slow_count_r) begin
                                left_lvl   = 8'(base_duty_r / 2);
                                slow_phase = 1;
                            end
                            b = (slow_phase != 0) ? 1 : 0;
                            trim_right(6 - b, 3 - b);
                        end
                    end
                    MODE_STRAIGHT_BRK: begin
                        if (it.ms_tick) begin
                            if (brake_left != 0) brake_left--;
                            if (brake_left == 0) begin
                                mode      = MODE_IDLE;
                                left_cnt  = 0;
                                right_cnt = 0;
                                done      = 1'b1;
                            end
                        end
                    end
                    MODE_TURN: begin
                        if (right_cnt > target_cnt) begin
                            mode       = MODE_IDLE;
                            turning_on = 1'b0;
                            left_cnt   = 0;
                            right_cnt  = 0;
                            done       = 1'b1;
                        end else begin
                            if (10 * left_cnt >= 7 * target_cnt &&
                                10 * right_cnt >= 7 * target_cnt) begin
                                left_lvl   = 8'(base_duty_r / 2);
                                slow_phase = 1;
                                if (10 * left_cnt >= 8 * target_cnt &&
                                    10 * right_cnt >= 8 * target_cnt) begin
                                    left_lvl   = 8'(base_duty_r / 3);
                                    slow_phase = 2;
                                    if (left_cnt + 2 >= target_cnt &&
                                        right_cnt + 2 >= target_cnt) begin
                                        mode       = MODE_TURN_BRK;
                                        brake_left = 4'(TURN_BRAKE_MS);
                                        turning_on = 1'b0;
                                    end
                                end
                            end
                            b = (slow_phase == 2) ? 3 : ((slow_phase == 1) ? 1 : 0);
                            trim_right(5 - b, 4 - b);
                        end
                    end
                    MODE_TURN_BRK: begin
                        if (it.ms_tick) begin
                            if (brake_left != 0) brake_left--;
                            if (brake_left == 0) mode = MODE_TURN;
                        end
                    end
                    default: mode = MODE_IDLE;
                endcase
            end
        endcase

        case (mode)
            MODE_STRAIGHT: begin
                r.left_fwd  = 1'b1;
                r.right_fwd = 1'b1;
            end
            MODE_STRAIGHT_BRK: begin
                r.left_rev  = 1'b1;
                r.right_rev = 1'b1;
            end
            MODE_TURN: begin
                r.left_fwd  = turning_on;
                r.right_rev = turning_on;
            end
            MODE_TURN_BRK: begin
                r.left_rev  = 1'b1;
                r.right_fwd = 1'b1;
            end
            default: ;
        endcase
        r.left_duty  = left_lvl;
        r.right_duty = right_lvl;
        r.busy_res   = (mode != MODE_IDLE);
        r.done_res   = done;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result  got;
        t_result  want;
        t_reg_idx idx;
        if (!i_rst_n) begin
            restore_defaults();
        end else begin
            // compare first: a result is never taken in the cycle its beat is accepted
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata[21:0]);
                if (drive_results_due.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d with nothing due", beats_out));
                end else begin
                    want = drive_results_due.pop_front();
                    if (got.left_fwd !== want.left_fwd)
                        report_mismatch($sformatf("beat %0d left_fwd %0b exp %0b",
                            beats_out, got.left_fwd, want.left_fwd));
                    if (got.left_rev !== want.left_rev)
                        report_mismatch($sformatf("beat %0d left_rev %0b exp %0b",
                            beats_out, got.left_rev, want.left_rev));
                    if (got.right_fwd !== want.right_fwd)
                        report_mismatch($sformatf("beat %0d right_fwd %0b exp %0b",
                            beats_out, got.right_fwd, want.right_fwd));
                    if (got.right_rev !== want.right_rev)
                        report_mismatch($sformatf("beat %0d right_rev %0b exp %0b",
                            beats_out, got.right_rev, want.right_rev));
                    if (got.left_duty !== want.left_duty)
                        report_mismatch($sformatf("beat %0d left_duty %0d exp %0d",
                            beats_out, got.left_duty, want.left_duty));
                    if (got.right_duty !== want.right_duty)
                        report_mismatch($sformatf("beat %0d right_duty %0d exp %0d",
                            beats_out, got.right_duty, want.right_duty));
                    if (got.busy_res !== want.busy_res)
                        report_mismatch($sformatf("beat %0d busy_res %0b exp %0b",
                            beats_out, got.busy_res, want.busy_res));
                    if (got.done_res !== want.done_res)
                        report_mismatch($sformatf("beat %0d done_res %0b exp %0b",
                            beats_out, got.done_res, want.done_res));
                end
                beats_out++;
            end

            if (i_psel && i_penable && i_pready) begin
                idx = t_reg_idx'(i_paddr[4:2]);
                if (i_pwrite) begin
                    write_reg(idx, i_pwdata);
                end else if (i_prdata !== reg_value(idx)) begin
                    report_mismatch($sformatf("register %s read %0h exp %0h",
                        idx.name(), i_prdata, reg_value(idx)));
                end
            end

            if (i_s_tvalid && i_s_tready)
                drive_results_due.push_back(step_drive(t_item'(i_s_tdata[4:0])));
        end
        pending = drive_results_due.size();
    end

endmodule

FILE: dv/tb_top.sv
module tb_top;
    import dws_pkg::*;

    localparam int unsigned STRAIGHT_BRAKE_MS = 7;
    localparam int unsigned TURN_BRAKE_MS     = 3;
    localparam int unsigned COUNT_WIDTH       = 16;

    // Random part: phases of at least this many beats, each with its own settings.
    localparam int PHASES          = 12;
    localparam int BEATS_PER_PHASE = 95;

    // The block treats the spare func code as a plain tick.
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // [1:0] func, [2] left_pulse, [3] right_pulse, [4] ms_tick, [7:5] zero
    logic [7:0]            s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [0] left_fwd, [1] left_rev, [2] right_fwd, [3] right_rev,
    // [11:4] left_duty, [19:12] right_duty, [20] busy_res, [21] done_res, [23:22] zero
    logic [23:0]           m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int results_due;

    // Idle-burst switches for each side; both go quiet for the last phases.
    bit sender_gaps = 1'b0;
    bit sink_gaps   = 1'b0;
    int sink_stall  = 0;

    two_wheel_encoder_drive_sync_unit #(
        .STRAIGHT_BRAKE_MS (STRAIGHT_BRAKE_MS),
        .TURN_BRAKE_MS     (TURN_BRAKE_MS),
        .COUNT_WIDTH       (COUNT_WIDTH)
    ) u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    drive_sync_checker #(
        .STRAIGHT_BRAKE_MS (STRAIGHT_BRAKE_MS),
        .TURN_BRAKE_MS     (TURN_BRAKE_MS),
        .COUNT_WIDTH       (COUNT_WIDTH)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (results_due)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run.
    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    // Result side: hold tready low for random bursts when enabled,
    // otherwise accept every beat.
    always @(negedge clk) begin
        if (sink_stall > 0) begin
            sink_stall--;
            m_tready = 1'b0;
        end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
            sink_stall = $urandom_range(1, 12) - 1;
            m_tready   = 1'b0;
        end else begin
            m_tready = 1'b1;
        end
    end

    function automatic t_item make_item(input logic [1:0] f, input bit lp, input bit rp,
                                        input bit ms);
        t_item it;
        it.func        = f;
        it.left_pulse  = lp;
        it.right_pulse = rp;
        it.ms_tick     = ms;
        return it;
    endfunction

    // One tick with pulse and millisecond odds in percent; now and then use the
    // spare func code, which must behave as a tick.
    function automatic t_item make_tick(input int lp_pct, input int rp_pct, input int ms_pct);
        logic [1:0] f;
        f = ($urandom_range(0, 24) == 0) ? FUNC_SPARE : FUNC_TICK;
        return make_item(f, $urandom_range(0, 99) < lp_pct, $urandom_range(0, 99) < rp_pct,
                         $urandom_range(0, 99) < ms_pct);
    endfunction

    // Present one beat and hold it until taken. Called and returns at a falling edge;
    // tvalid stays high, so back-to-back beats stream without a bubble when no gap is drawn.
    task automatic send_beat(input t_item it);
        int n;
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            n        = $urandom_range(1, 12);
            s_tvalid = 1'b0;
            repeat (n) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {3'b000, it};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // Setup cycle, then access cycle; the access completes on the edge with pready.
    task automatic apb_access(input bit wr, input t_reg_idx idx, input logic [31:0] v);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = wr ? v : '0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Write every register, then read each back; the checker compares reads.
    task automatic load_settings(input int tmm, input int mult, input int rot, input int base,
                                 input int dmax, input int dmin, input int slow,
                                 input int boost);
        apb_access(1'b1, REG_TARGET_MM,     32'(tmm));
        apb_access(1'b1, REG_TURN_MULTIPLE, 32'(mult));
        apb_access(1'b1, REG_ROTATION,      32'(rot));
        apb_access(1'b1, REG_BASE_DUTY,     32'(base));
        apb_access(1'b1, REG_DUTY_MAX,      32'(dmax));
        apb_access(1'b1, REG_DUTY_MIN,      32'(dmin));
        apb_access(1'b1, REG_SLOW_COUNT,    32'(slow));
        apb_access(1'b1, REG_START_BOOST,   32'(boost));
        for (int i = 0; i < 8; i++)
            apb_access(1'b0, t_reg_idx'(i), '0);
    endtask

    // Stop sending and wait until every predicted result has come back, then
    // let the output register settle.
    task automatic drain();
        s_tvalid = 1'b0;
        while (results_due != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    initial begin
        int    sent;
        int    len;
        int    lp_pct;
        int    rp_pct;
        int    ms_pct;
        int    dmax;
        int    dmin;
        t_item it;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---------------- directed ----------------
        // Straight target 4 pulses, slow phase from left count 2, boost saturates
        // (15+250), clamps crossed (max 100 below min 120). Turn target 4 with a
        // base duty below twenty, so the turn-start duty bottoms out at zero.
        load_settings(2, 2, 2, 15, 100, 120, 2, 250);

        // pulses while idle count; spare func code acts as a tick
        send_beat(make_item(FUNC_TICK,  1'b1, 1'b0, 1'b0));
        send_beat(make_item(FUNC_SPARE, 1'b1, 1'b1, 1'b1));
        // straight start: pulses on the start beat are dropped
        send_beat(make_item(FUNC_STRAIGHT, 1'b1, 1'b1, 1'b1));
        // left ahead (raise, slow phase), then right ahead (lower), then pass target
        send_beat(make_item(FUNC_TICK, 1'b1, 1'b0, 1'b0));
        send_beat(make_item(FUNC_TICK, 1'b1, 1'b0, 1'b0));
        send_beat(make_item(FUNC_TICK, 1'b0, 1'b1, 1'b0));
        send_beat(make_item(FUNC_TICK, 1'b0, 1'b1, 1'b0));
        send_beat(make_item(FUNC_TICK, 1'b0, 1'b1, 1'b0));
        send_beat(make_item(FUNC_TICK, 1'b1, 1'b1, 1'b0));
        send_beat(make_item(FUNC_TICK, 1'b1, 1'b1, 1'b0));
        // reverse brake runs out on millisecond ticks; pulses still counted
        repeat (STRAIGHT_BRAKE_MS)
            send_beat(make_item(FUNC_TICK, 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)), 1'b1));
        // turn, aborted at once by a straight start, then a fresh turn
        send_beat(make_item(FUNC_TURN,     1'b0, 1'b1, 1'b0));
        send_beat(make_item(FUNC_STRAIGHT, 1'b0, 1'b0, 1'b0));
        send_beat(make_item(FUNC_TURN,     1'b1, 1'b0, 1'b1));
        // both wheels step through the 70% and 80% phases into the turn brake
        repeat (4) send_beat(make_item(FUNC_TICK, 1'b1, 1'b1, 1'b0));
        // brake ends, gates stay off, then right passes the target: done
        repeat (TURN_BRAKE_MS) send_beat(make_item(FUNC_TICK, 1'b0, 1'b0, 1'b1));
        send_beat(make_item(FUNC_TICK, 1'b0, 1'b1, 1'b0));
        drain();

        // ---------------- random phases ----------------
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                1: load_settings(0, 0, 1, 0, 0, 0, 0, 0);
                2: load_settings(16383, 4, 4095, 255, 255, 255, 65535, 255);
                default: begin
                    if ($urandom_range(0, 4) == 0) begin
                        // crossed or arbitrary clamps
                        dmax = $urandom_range(0, 255);
                        dmin = $urandom_range(0, 255);
                    end else begin
                        dmax = $urandom_range(128, 255);
                        dmin = $urandom_range(0, 127);
                    end
                    // small targets so moves finish and brakes get exercised
                    load_settings($urandom_range(1, 20), $urandom_range(0, 4),
                                  $urandom_range(1, 15), $urandom_range(0, 255), dmax, dmin,
                                  $urandom_range(0, 50),
                                  ($urandom_range(0, 1) != 0) ? $urandom_range(0, 255) : 0);
                end
            endcase

            sender_gaps = (p < PHASES - 2) && ($urandom_range(0, 3) != 0);
            sink_gaps   = (p < PHASES - 2) && ($urandom_range(0, 3) != 0);

            sent = 0;
            while (sent < BEATS_PER_PHASE) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise: any beat, any func code
                    it = t_item'(5'($urandom_range(0, 31)));
                    send_beat(it);
                    sent++;
                end else begin
                    // well-formed move: a start, then a stream of ticks; some are
                    // cut short so the next start aborts them
                    lp_pct = $urandom_range(40, 95);
                    rp_pct = $urandom_range(40, 95);
                    ms_pct = $urandom_range(20, 60);
                    it = make_item(($urandom_range(0, 1) != 0) ? FUNC_STRAIGHT : FUNC_TURN,
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)));
                    send_beat(it);
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6)
                                                      : $urandom_range(15, 90);
                    repeat (len) send_beat(make_tick(lp_pct, rp_pct, ms_pct));
                    sent += len + 1;
                    // hold off now and then until the pipeline is empty
                    if ($urandom_range(0, 9) == 0) drain();
                end
            end
            drain();
        end

        drain();
        repeat (5) @(posedge clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
